### sv/point4d_query_filter_distance_macros.svh
// Assertion macros used by the checker file of the point query filter.
`ifndef POINT4D_QUERY_FILTER_DISTANCE_MACROS_SVH
`define POINT4D_QUERY_FILTER_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PQFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PQFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pqfd_pkg.sv
// Shared types, constants and helpers of the 4D point query filter.
package pqfd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int SLOT_W         = 16;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int RAD_W          = 16;
    localparam int DIST_W         = 17;

    typedef enum logic [1:0] {
        KIND_EQUAL  = 2'd0,
        KIND_BOX    = 2'd1,
        KIND_SPHERE = 2'd2,
        KIND_ANY    = 2'd3
    } t_query_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KIND     = 3'd0,
        REG_LOW      = 3'd1,
        REG_HIGH     = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_ORDER_EN = 3'd4,
        REG_ORDER_PT = 3'd5
    } t_cfg_reg;

    // Three front stages plus one square-root stage per two root bits.
    function automatic int pipe_depth(input int coord_bits);
        return 3 + ((coord_bits + 2) >> 1);
    endfunction

endpackage

### sv/pqfd_in_if.sv
// Candidate point channel: valid/ready plus four signed Q8.8 coordinates.
interface pqfd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic signed [15:0] coord_w;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output coord_w, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    input coord_w, output ready);
endinterface

### sv/pqfd_out_if.sv
// Result channel: valid/ready plus match flag and unsigned Q9.8 distance.
interface pqfd_out_if;
    logic        valid;
    logic        ready;
    logic        match;
    logic [16:0] distance;

    modport source (output valid, output match, output distance, input ready);
    modport sink   (input valid, input match, input distance, output ready);
endinterface

### sv/point4d_query_filter_distance.sv
// Throughput: one word per cycle unless the output stalls; every stage has its own valid bit
// and empty stages fill while the output stalls, so a waiting result blocks new input only
// once every stage holds a word.
// Stages: compare and difference, squares, sums and match, then two root bits per stage.
// Reset (synchronous, active low) empties the pipeline and sets the query to no filter.
module point4d_query_filter_distance #(
    parameter int COORD_BITS = pqfd_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pqfd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pqfd_pkg::CFG_W-1:0]          i_cfg_data,
    pqfd_in_if.sink                             i_in,
    pqfd_out_if.source                          o_out
);

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int AW    = CB;
    localparam int SQW   = 2 * CB;
    localparam int SW    = 2 * CB + 2;
    localparam int RW    = CB + 1;
    localparam int RMW   = RW + 2;
    localparam int NS    = (RW + 1) / 2;
    localparam int DEPTH = pqfd_pkg::pipe_depth(CB);
    localparam int RRW   = 2 * pqfd_pkg::RAD_W;
    localparam int CMPW  = (SW > RRW) ? SW : RRW;
    localparam int SL    = pqfd_pkg::SLOT_W;

    // Configuration registers
    pqfd_pkg::t_query_kind           r_kind;
    logic [pqfd_pkg::CFG_W-1:0]      r_lo;
    logic [pqfd_pkg::CFG_W-1:0]      r_hi;
    logic [pqfd_pkg::RAD_W-1:0]      r_rad;
    logic                            r_oen;
    logic [pqfd_pkg::CFG_W-1:0]      r_opt;

    // Handshake
    logic [DEPTH-1:0] r_v;
    logic [DEPTH:0]   rdy;

    // Stage 1
    logic signed [CB-1:0] c1_p [4];
    logic [AW-1:0] n1_abs_s [4];
    logic [AW-1:0] n1_abs_o [4];
    logic          n1_eq;
    logic          n1_box;
    logic [AW-1:0] r1_abs_s [4];
    logic [AW-1:0] r1_abs_o [4];
    logic          r1_eq;
    logic          r1_box;

    // Stage 2
    logic [SQW-1:0] n2_sq_s [4];
    logic [SQW-1:0] n2_sq_o [4];
    logic [SQW-1:0] r2_sq_s [4];
    logic [SQW-1:0] r2_sq_o [4];
    logic           r2_eq;
    logic           r2_box;
    logic [RRW-1:0] r2_rr;

    // Stage 3
    logic [SW-1:0] c3_sum_s;
    logic [SW-1:0] c3_sum_o;
    logic          n3_match;
    logic          r3_match;
    logic [SW-1:0] r3_num;

    // Square-root stages
    logic [SW-1:0]  r_num   [NS];
    logic [RMW-1:0] r_rem   [NS];
    logic [RW-1:0]  r_root  [NS];
    logic           r_match [NS];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= pqfd_pkg::KIND_ANY;
            r_lo   <= '0;
            r_hi   <= '0;
            r_rad  <= '0;
            r_oen  <= 1'b0;
            r_opt  <= '0;
        end else if (i_cfg_we) begin
            case (pqfd_pkg::t_cfg_reg'(i_cfg_idx))
                pqfd_pkg::REG_KIND:     r_kind <= pqfd_pkg::t_query_kind'(i_cfg_data[1:0]);
                pqfd_pkg::REG_LOW:      r_lo   <= i_cfg_data;
                pqfd_pkg::REG_HIGH:     r_hi   <= i_cfg_data;
                pqfd_pkg::REG_RADIUS:   r_rad  <= i_cfg_data[pqfd_pkg::RAD_W-1:0];
                pqfd_pkg::REG_ORDER_EN: r_oen  <= i_cfg_data[0];
                pqfd_pkg::REG_ORDER_PT: r_opt  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ready chain: a stage loads when it is empty or its word moves on
    always_comb begin
        rdy[DEPTH] = o_out.ready;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            rdy[k] = ~r_v[k] | rdy[k+1];
        end
    end

    assign i_in.ready = rdy[0];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < DEPTH; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: narrow coordinates, compare, take absolute differences
    always_comb begin
        logic signed [CB-1:0] lo;
        logic signed [CB-1:0] hi;
        logic signed [CB-1:0] op;
        logic signed [DW-1:0] ds;
        logic signed [DW-1:0] dor;
        c1_p[0] = $signed(i_in.coord_x[CB-1:0]);
        c1_p[1] = $signed(i_in.coord_y[CB-1:0]);
        c1_p[2] = $signed(i_in.coord_z[CB-1:0]);
        c1_p[3] = $signed(i_in.coord_w[CB-1:0]);
        n1_eq  = 1'b1;
        n1_box = 1'b1;
        for (int k = 0; k < 4; k++) begin
            lo  = $signed(r_lo[SL*k +: CB]);
            hi  = $signed(r_hi[SL*k +: CB]);
            op  = $signed(r_opt[SL*k +: CB]);
            ds  = DW'(c1_p[k]) - DW'(lo);
            dor = DW'(c1_p[k]) - DW'(op);
            n1_abs_s[k] = ds[DW-1]  ? AW'(-ds)  : AW'(ds);
            n1_abs_o[k] = dor[DW-1] ? AW'(-dor) : AW'(dor);
            if (c1_p[k] != lo) begin
                n1_eq = 1'b0;
            end
            if (c1_p[k] < lo || c1_p[k] > hi) begin
                n1_box = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_abs_s <= n1_abs_s;
            r1_abs_o <= n1_abs_o;
            r1_eq    <= n1_eq;
            r1_box   <= n1_box;
        end
    end

    // Stage 2: square each difference, square the radius
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n2_sq_s[k] = SQW'(r1_abs_s[k]) * SQW'(r1_abs_s[k]);
            n2_sq_o[k] = SQW'(r1_abs_o[k]) * SQW'(r1_abs_o[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r2_sq_s <= n2_sq_s;
            r2_sq_o <= n2_sq_o;
            r2_eq   <= r1_eq;
            r2_box  <= r1_box;
            r2_rr   <= RRW'(r_rad) * RRW'(r_rad);
        end
    end

    // Stage 3: sum squares, resolve the match, gate the root operand
    always_comb begin
        c3_sum_s = SW'(r2_sq_s[0]) + SW'(r2_sq_s[1]) + SW'(r2_sq_s[2]) + SW'(r2_sq_s[3]);
        c3_sum_o = SW'(r2_sq_o[0]) + SW'(r2_sq_o[1]) + SW'(r2_sq_o[2]) + SW'(r2_sq_o[3]);
        case (r_kind)
            pqfd_pkg::KIND_EQUAL:  n3_match = r2_eq;
            pqfd_pkg::KIND_BOX:    n3_match = r2_box;
            pqfd_pkg::KIND_SPHERE: n3_match = (CMPW'(c3_sum_s) <= CMPW'(r2_rr));
            pqfd_pkg::KIND_ANY:    n3_match = 1'b1;
            default:               n3_match = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r3_match <= n3_match;
            r3_num   <= (n3_match && r_oen) ? c3_sum_o : '0;
        end
    end

    // Square-root stages: restoring digit method, two root bits per stage
    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        logic [SW-1:0]  num_in;
        logic [RMW-1:0] rem_in;
        logic [RW-1:0]  root_in;
        logic           match_in;
        logic [SW-1:0]  n_num;
        logic [RMW-1:0] n_rem;
        logic [RW-1:0]  n_root;

        if (j == 0) begin : g_first
            assign num_in   = r3_num;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign match_in = r3_match;
        end else begin : g_next
            assign num_in   = r_num[j-1];
            assign rem_in   = r_rem[j-1];
            assign root_in  = r_root[j-1];
            assign match_in = r_match[j-1];
        end

        always_comb begin
            logic [RMW+1:0] rt;
            logic [RMW+1:0] trial;
            n_num  = num_in;
            n_rem  = rem_in;
            n_root = root_in;
            rt     = '0;
            trial  = '0;
            for (int t = 0; t < 2; t++) begin
                if (2 * j + t < RW) begin
                    rt    = {n_rem, n_num[SW-1 -: 2]};
                    trial = (RMW + 2)'({n_root, 2'b01});
                    n_num = {n_num[SW-3:0], 2'b00};
                    if (rt >= trial) begin
                        n_rem  = RMW'(rt - trial);
                        n_root = {n_root[RW-2:0], 1'b1};
                    end else begin
                        n_rem  = RMW'(rt);
                        n_root = {n_root[RW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[3+j]) begin
                r_num[j]   <= n_num;
                r_rem[j]   <= n_rem;
                r_root[j]  <= n_root;
                r_match[j] <= match_in;
            end
        end
    end

    // Drive the result word from the last stage
    assign o_out.valid    = r_v[DEPTH-1];
    assign o_out.match    = r_match[NS-1];
    assign o_out.distance = pqfd_pkg::DIST_W'(r_root[NS-1]);

endmodule

### sv/pqfd_checker.sv
// Port-level checker for the point query filter, bound to the top level.
`include "point4d_query_filter_distance_macros.svh"

module pqfd_checker #(
    parameter int COORD_BITS = pqfd_pkg::COORD_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_match,
    input logic [pqfd_pkg::DIST_W-1:0] i_out_distance
);

    localparam int DEPTH = pqfd_pkg::pipe_depth(COORD_BITS);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    // Track words in flight
    always_comb begin
        n_cnt = r_cnt;
        if (i_in_valid && i_in_ready) begin
            n_cnt = n_cnt + CW'(1);
        end
        if (i_out_valid && i_out_ready) begin
            n_cnt = n_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `PQFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_match) && $stable(i_out_distance), "result word changed while stalled")
    `PQFD_ASSERT_IMP(a_dist_zero, i_clk, i_rst_n, i_out_valid && !i_out_match, i_out_distance == '0, "nonzero distance on a non-matching word")
    `PQFD_ASSERT_IMP(a_no_phantom, i_clk, i_rst_n, i_out_valid, r_cnt != '0, "result word without an accepted input word")
    `PQFD_ASSERT_IMP(a_depth, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DEPTH), "more words in flight than pipeline stages")

endmodule

bind point4d_query_filter_distance pqfd_checker #(
    .COORD_BITS (COORD_BITS)
) u_pqfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_match    (o_out.match),
    .i_out_distance (o_out.distance)
);

### bench/tb.sv
// Self-checking bench for the 4D point query filter: predicted verdicts versus the block's results.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = pqfd_pkg::COORD_BITS_DEF;
    localparam int DRAIN      = pqfd_pkg::pipe_depth(COORD_BITS) + 4;
    localparam int WATCHDOG   = 2000;
    localparam int HOLD_OFF   = 300;
    localparam int PHASE_LEN  = 100;
    localparam int PHASES     = 9;

    typedef logic signed [15:0] t_coord;

    // Packed so that x sits in bits 15:0, as in the corner registers.
    typedef struct packed {
        t_coord w;
        t_coord z;
        t_coord y;
        t_coord x;
    } t_point;

    typedef struct packed {
        logic                        match;
        logic [pqfd_pkg::DIST_W-1:0] distance;
    } t_verdict;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [pqfd_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [pqfd_pkg::CFG_W-1:0]     cfg_data;

    pqfd_in_if  pt_if ();
    pqfd_out_if res_if ();

    point4d_query_filter_distance dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (pt_if),
        .o_out      (res_if)
    );

    // Shadow copy of the query registers
    pqfd_pkg::t_query_kind q_kind;
    t_point        q_low;
    t_point        q_high;
    logic [15:0]   q_radius;
    logic          q_order_en;
    t_point        q_order;

    t_point   points_to_send[$];
    t_verdict verdicts_due[$];

    t_point   next_pt;
    t_point   cand;
    t_verdict want;
    int       send_gap;
    int       rcv_wait;
    bit       send_gaps_on;
    bit       rcv_stalls_on;
    bit       pressure_arm;
    bit       pressure_taken;
    int       quiet_cycles;
    int       errors;
    int       results_seen;
    int       points_in;
    int       hits;
    int       ordered_hits;
    int       settings_run;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Low COORD_BITS of a slot, sign-extended
    function automatic longint widen(logic [15:0] v);
        longint r;
        r = longint'(v) & ((longint'(1) << COORD_BITS) - 1);
        if (r[COORD_BITS-1])
            r = r - (longint'(1) << COORD_BITS);
        return r;
    endfunction

    function automatic logic [15:0] slot(t_point p, int k);
        logic [63:0] v;
        v = p;
        return v[16*k +: 16];
    endfunction

    function automatic logic [63:0] sq_span(t_point a, t_point b);
        logic [63:0] acc;
        longint      d;
        acc = '0;
        for (int k = 0; k < 4; k++) begin
            d   = widen(slot(a, k)) - widen(slot(b, k));
            acc = acc + 64'(d * d);
        end
        return acc;
    endfunction

    // Floor square root, one result bit at a time from the top
    function automatic logic [pqfd_pkg::DIST_W-1:0] root_floor(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = pqfd_pkg::DIST_W - 1; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        return r[pqfd_pkg::DIST_W-1:0];
    endfunction

    function automatic t_verdict filter_verdict(t_point p);
        t_verdict v;
        logic     hit;
        hit = 1'b1;
        case (q_kind)
            pqfd_pkg::KIND_EQUAL: begin
                for (int k = 0; k < 4; k++)
                    if (widen(slot(p, k)) != widen(slot(q_low, k)))
                        hit = 1'b0;
            end
            pqfd_pkg::KIND_BOX: begin
                for (int k = 0; k < 4; k++)
                    if (widen(slot(p, k)) < widen(slot(q_low, k)) ||
                        widen(slot(p, k)) > widen(slot(q_high, k)))
                        hit = 1'b0;
            end
            pqfd_pkg::KIND_SPHERE: begin
                hit = sq_span(p, q_low) <= 64'(q_radius) * 64'(q_radius);
            end
            default: ;
        endcase
        v.match    = hit;
        v.distance = (hit && q_order_en) ? root_floor(sq_span(p, q_order)) : '0;
        return v;
    endfunction

    function automatic t_point mk_point(int x, int y, int z, int w);
        t_point p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.z = 16'(z);
        p.w = 16'(w);
        return p;
    endfunction

    function automatic t_point rand_point();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] clip16(int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    // Write one query register and mirror it in the shadow copy
    task automatic set_reg(pqfd_pkg::t_cfg_reg idx, logic [pqfd_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            pqfd_pkg::REG_KIND:     q_kind     = pqfd_pkg::t_query_kind'(val[1:0]);
            pqfd_pkg::REG_LOW:      q_low      = val;
            pqfd_pkg::REG_HIGH:     q_high     = val;
            pqfd_pkg::REG_RADIUS:   q_radius   = val[15:0];
            pqfd_pkg::REG_ORDER_EN: q_order_en = val[0];
            pqfd_pkg::REG_ORDER_PT: q_order    = val;
            default: ;
        endcase
    endtask

    task automatic set_kind(pqfd_pkg::t_query_kind k);
        set_reg(pqfd_pkg::REG_KIND, {$urandom, 30'($urandom), 2'(k)});
    endtask

    task automatic set_order(bit en, t_point pt);
        set_reg(pqfd_pkg::REG_ORDER_EN, {$urandom, 31'($urandom), en});
        set_reg(pqfd_pkg::REG_ORDER_PT, pt);
    endtask

    // Wait until every queued point went in and every result came back
    task automatic wait_drain();
        do
            @(negedge i_clk);
        while (points_to_send.size() != 0 || pt_if.valid || verdicts_due.size() != 0);
        repeat (DRAIN) @(negedge i_clk);
        settings_run++;
    endtask

    // One random query setting followed by mostly well-formed candidates
    task automatic random_phase(pqfd_pkg::t_query_kind k, bit pressure);
        t_point lo;
        t_point hi;
        t_point p;
        t_point ord;
        int     a;
        int     b;
        int     span;
        int     r;
        bit     empty_box;
        lo = rand_point();
        hi = rand_point();
        empty_box = ($urandom_range(0, 3) == 0);
        // Sort the corners per coordinate unless an empty box is wanted
        for (int c = 0; c < 4; c++) begin
            a = int'(widen(slot(lo, c)));
            b = int'(widen(slot(hi, c)));
            if (a > b && !empty_box) begin
                lo[16*c +: 16] = 16'(b);
                hi[16*c +: 16] = 16'(a);
            end
        end
        case ($urandom_range(0, 4))
            0:       r = 0;
            1:       r = 65535;
            2:       r = $urandom_range(0, 255);
            default: r = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 3))
            0:       ord = {4{16'h8000}};
            1:       ord = {4{16'h7fff}};
            default: ord = rand_point();
        endcase
        set_kind(k);
        set_reg(pqfd_pkg::REG_LOW, lo);
        set_reg(pqfd_pkg::REG_HIGH, hi);
        set_reg(pqfd_pkg::REG_RADIUS, {$urandom, 16'($urandom), 16'(r)});
        set_order($urandom_range(0, 2) != 0, ord);
        @(negedge i_clk);
        send_gaps_on  = pressure ? 1'b0 : ($urandom_range(0, 2) != 0);
        rcv_stalls_on = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
        pressure_arm  = pressure;
        for (int i = 0; i < PHASE_LEN; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                p = rand_point();
            end else begin
                case (k)
                    pqfd_pkg::KIND_EQUAL: begin
                        p = lo;
                        if ($urandom_range(0, 2) == 0)
                            p = p ^ (64'd1 << $urandom_range(0, 63));
                    end
                    pqfd_pkg::KIND_BOX: begin
                        p = rand_point();
                        for (int c = 0; c < 4; c++) begin
                            a = int'(widen(slot(lo, c)));
                            b = int'(widen(slot(hi, c)));
                            if (a <= b)
                                p[16*c +: 16] = 16'(a + int'($urandom_range(0, b - a)));
                        end
                    end
                    pqfd_pkg::KIND_SPHERE: begin
                        // Half-radius offsets land inside, full-radius ones straddle the edge
                        span = ($urandom_range(0, 1) == 0) ? r / 2 : r;
                        for (int c = 0; c < 4; c++)
                            p[16*c +: 16] = clip16(int'(widen(slot(lo, c))) +
                                int'($urandom_range(0, 2 * span)) - span);
                    end
                    default: p = rand_point();
                endcase
            end
            points_to_send.push_back(p);
        end
        wait_drain();
    endtask

    // Stimulus and phase sequencing
    initial begin
        pqfd_pkg::t_query_kind k;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = pqfd_pkg::REG_KIND;
        cfg_data       = '0;
        pt_if.valid    = 1'b0;
        pt_if.coord_x  = '0;
        pt_if.coord_y  = '0;
        pt_if.coord_z  = '0;
        pt_if.coord_w  = '0;
        res_if.ready   = 1'b0;
        q_kind         = pqfd_pkg::KIND_ANY;
        q_low          = '0;
        q_high         = '0;
        q_radius       = '0;
        q_order_en     = 1'b0;
        q_order        = '0;
        send_gaps_on   = 1'b1;
        rcv_stalls_on  = 1'b1;
        pressure_arm   = 1'b0;
        errors         = 0;
        settings_run   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // No filter from reset, ordering off
        @(negedge i_clk);
        points_to_send.push_back(mk_point(32767, 32767, 32767, 32767));
        points_to_send.push_back(mk_point(-32768, -32768, -32768, -32768));
        wait_drain();

        // No filter, distance to the far corner of the coordinate space
        set_kind(pqfd_pkg::KIND_ANY);
        set_order(1'b1, {4{16'h8000}});
        @(negedge i_clk);
        points_to_send.push_back(mk_point(32767, 32767, 32767, 32767));
        points_to_send.push_back(mk_point(-32768, -32768, -32768, -32768));
        wait_drain();

        // Exact equality: the point itself, then one coordinate off
        set_kind(pqfd_pkg::KIND_EQUAL);
        set_reg(pqfd_pkg::REG_LOW, mk_point(300, -7, 0, -32768));
        set_order(1'b1, mk_point(0, 0, 0, 0));
        @(negedge i_clk);
        points_to_send.push_back(mk_point(300, -7, 0, -32768));
        points_to_send.push_back(mk_point(301, -7, 0, -32768));
        points_to_send.push_back(mk_point(300, -7, 0, 32767));
        wait_drain();

        // Inclusive box: both corners hit, one step past a face misses
        set_kind(pqfd_pkg::KIND_BOX);
        set_reg(pqfd_pkg::REG_LOW, mk_point(-32768, -100, 0, 5));
        set_reg(pqfd_pkg::REG_HIGH, mk_point(32767, 100, 0, 300));
        set_order(1'b0, mk_point(1, 2, 3, 4));
        @(negedge i_clk);
        points_to_send.push_back(mk_point(-32768, -100, 0, 5));
        points_to_send.push_back(mk_point(32767, 100, 0, 300));
        points_to_send.push_back(mk_point(0, -101, 0, 100));
        points_to_send.push_back(mk_point(0, 0, 1, 100));
        points_to_send.push_back(mk_point(0, 0, 0, 301));
        wait_drain();

        // Box with a raised low y corner: a point on that face still hits
        set_reg(pqfd_pkg::REG_LOW, mk_point(-10, 50, -10, -10));
        @(negedge i_clk);
        points_to_send.push_back(mk_point(0, 50, 0, 0));
        wait_drain();

        // Zero radius holds only the center
        set_kind(pqfd_pkg::KIND_SPHERE);
        set_reg(pqfd_pkg::REG_LOW, mk_point(1000, -1000, 2, -2));
        set_reg(pqfd_pkg::REG_RADIUS, 64'd0);
        set_order(1'b1, mk_point(-1, 1, -1, 1));
        @(negedge i_clk);
        points_to_send.push_back(mk_point(1000, -1000, 2, -2));
        points_to_send.push_back(mk_point(1000, -1000, 3, -2));
        wait_drain();

        // Sphere edge exactly at the radius, and the largest radius
        set_reg(pqfd_pkg::REG_LOW, 64'd0);
        set_reg(pqfd_pkg::REG_RADIUS, 64'd3);
        @(negedge i_clk);
        points_to_send.push_back(mk_point(2, 2, 1, 0));
        points_to_send.push_back(mk_point(2, 2, 1, 1));
        wait_drain();
        set_reg(pqfd_pkg::REG_RADIUS, 64'hffff);
        @(negedge i_clk);
        points_to_send.push_back(mk_point(32767, 32767, 32767, 32767));
        points_to_send.push_back(mk_point(-32768, -32768, -32768, -32768));
        wait_drain();

        // Random settings, each kind in turn, one with a long output stall
        for (int ph = 0; ph < PHASES; ph++) begin
            k = (ph < 8) ? pqfd_pkg::t_query_kind'(ph % 4)
                         : pqfd_pkg::t_query_kind'($urandom_range(0, 3));
            random_phase(k, ph == 2);
        end

        errors += verdicts_due.size();
        $display("Covered %0d points under %0d query settings: %0d matched, %0d with distance.",
                 points_in, settings_run, hits, ordered_hits);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Driver: hold the word while stalled, draw a gap after each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
            send_gap = 0;
        end else if (!(pt_if.valid && !pt_if.ready)) begin
            if (pt_if.valid)
                send_gap = send_gaps_on ? $urandom_range(0, 10) : 0;
            if (send_gap > 0 || points_to_send.size() == 0) begin
                if (send_gap > 0)
                    send_gap--;
                pt_if.valid <= 1'b0;
            end else begin
                next_pt = points_to_send.pop_front();
                pt_if.valid   <= 1'b1;
                pt_if.coord_x <= next_pt.x;
                pt_if.coord_y <= next_pt.y;
                pt_if.coord_z <= next_pt.z;
                pt_if.coord_w <= next_pt.w;
            end
        end
    end

    // Receiver: random stalls per word, plus one long hold-off when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rcv_wait = 0;
            pressure_taken = 1'b0;
        end else begin
            if (res_if.valid && res_if.ready)
                rcv_wait = rcv_stalls_on ? $urandom_range(0, 10) : 0;
            if (pressure_arm && !pressure_taken) begin
                rcv_wait = HOLD_OFF;
                pressure_taken = 1'b1;
            end
            if (rcv_wait > 0) begin
                rcv_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input words, compare on output words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pt_if.valid && pt_if.ready) begin
                cand.x = pt_if.coord_x;
                cand.y = pt_if.coord_y;
                cand.z = pt_if.coord_z;
                cand.w = pt_if.coord_w;
                verdicts_due.push_back(filter_verdict(cand));
                points_in++;
            end
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (verdicts_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: unexpected word match=%0b distance=%0d",
                                 results_seen, res_if.match, res_if.distance);
                end else begin
                    want = verdicts_due.pop_front();
                    if (want.match)
                        hits++;
                    if (want.distance != '0)
                        ordered_hits++;
                    if (res_if.match !== want.match || res_if.distance !== want.distance) begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d: match exp %0b got %0b, distance exp %0d got %0d",
                                     results_seen, want.match, res_if.match, want.distance,
                                     res_if.distance);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

### filelist.f
+incdir+sv
sv/pqfd_pkg.sv
sv/pqfd_in_if.sv
sv/pqfd_out_if.sv
sv/point4d_query_filter_distance.sv
sv/pqfd_checker.sv
bench/tb.sv
